FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the cache rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define LKVC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define LKVC_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LKVC_ASSERT(name, clk, rst_n, prop, msg)
`define LKVC_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_SET = 1'b1
  } lkvc_func_e;

  // controller to datapath
  typedef struct packed {
    logic accept;      // latch the word, restart the scan
    logic scan;        // walk the key memory
    logic commit_set;  // apply a set (update, evict or fill)
    logic respond;     // load the result register, refresh recency on hit
  } lkvc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // last entry compared this cycle
    logic is_set;      // latched word is a set
    logic out_free;    // result register can take a new word
  } lkvc_sts_t;

endpackage

FILE: rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// sequencer for accept, key scan, commit and response
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lkvc_pkg::lkvc_sts_t sts_i,
  output lkvc_pkg::lkvc_cmd_t cmd_o
);
  import lkvc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_RESP   = 4'b1000
  } lkvc_state_e;

  lkvc_state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    in_stall_o      = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_set) begin
          cmd_o.commit_set = 1'b1;
          state_d          = S_IDLE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LKVC_ASSERT(a_done_in_scan, clk_i, rst_ni, sts_i.scan_done |-> state_q == S_SCAN, "scan done outside scan")
  `LKVC_ASSERT(a_commit_is_set, clk_i, rst_ni, cmd_o.commit_set |-> sts_i.is_set, "commit on a get")

endmodule

FILE: rtl/lkvc_dp.sv
// ----------------------------------------------------------------------------
// lkvc_dp
// key/data memories, recency ranks, scan accumulators and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkvc_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  logic                                func_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   lookup_key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  store_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lkvc_pkg::DATA_W-1:0]  read_value_o,
  output logic                                hit_o,
  input  lkvc_pkg::lkvc_cmd_t                 cmd_i,
  output lkvc_pkg::lkvc_sts_t                 sts_o
);
  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [EW-1:0] MAX_CAP  = EW'(ENTRIES);

  // memories
  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [DATA_W-1:0] data_mem [ENTRIES];
  logic [KEY_W-1:0]  key_rd_q;
  logic [DATA_W-1:0] data_rd_q;

  // per entry state
  logic [ENTRIES-1:0] valid_q;
  logic [AW-1:0]      age_q [ENTRIES];

  // latched word and config
  logic              func_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] value_q;
  logic [CAP_W-1:0]  capacity_q;

  // scan
  logic          iss_on_q;
  logic [IW-1:0] iss_idx_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q;
  logic [IW-1:0] hit_idx_q;
  logic [AW-1:0] hit_age_q;
  logic [CW-1:0] count_q;
  logic          have_old_q;
  logic [IW-1:0] old_idx_q;
  logic [AW-1:0] old_age_q;
  logic          have_free_q;
  logic [IW-1:0] free_idx_q;

  // result
  logic              out_valid_q;
  logic [DATA_W-1:0] read_value_q;
  logic              hit_q;

  logic          cur_valid;
  logic [AW-1:0] cur_age;
  logic [EW-1:0] cap_eff;
  logic          evict;
  logic          fill_en;
  logic          touch_en;
  logic [IW-1:0] tgt_idx;
  logic [AW-1:0] tgt_age;
  logic [IW-1:0] wr_idx;

  assign cur_valid = valid_q[cmp_idx_q];
  assign cur_age   = age_q[cmp_idx_q];

  always_comb begin
    cap_eff = EW'(capacity_q);
    if (cap_eff == '0) cap_eff = EW'(1);
    else if (cap_eff > MAX_CAP) cap_eff = MAX_CAP;
  end

  assign evict    = EW'(count_q) >= cap_eff;
  assign fill_en  = cmd_i.commit_set && !found_q && !evict;
  assign touch_en = (cmd_i.commit_set && (found_q || evict)) || (cmd_i.respond && found_q);
  assign tgt_idx  = found_q ? hit_idx_q : old_idx_q;
  assign tgt_age  = found_q ? hit_age_q : old_age_q;

  always_comb begin
    priority if (found_q) wr_idx = hit_idx_q;
    else if (evict)       wr_idx = old_idx_q;
    else                  wr_idx = free_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_set && !found_q) key_mem[wr_idx] <= key_q;
    key_rd_q <= key_mem[iss_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_set) data_mem[wr_idx] <= value_q;
    data_rd_q <= data_mem[hit_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q  <= func_i;
      key_q   <= lookup_key_i;
      value_q <= store_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // one entry compared per cycle, in the cycle after its key read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_on_q    <= 1'b0;
      iss_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      hit_idx_q   <= '0;
      hit_age_q   <= '0;
      count_q     <= '0;
      have_old_q  <= 1'b0;
      old_idx_q   <= '0;
      old_age_q   <= '0;
      have_free_q <= 1'b0;
      free_idx_q  <= '0;
    end else if (cmd_i.accept) begin
      iss_on_q    <= 1'b1;
      iss_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      hit_idx_q   <= '0;
      count_q     <= '0;
      have_old_q  <= 1'b0;
      have_free_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan && iss_on_q;
      cmp_idx_q <= iss_idx_q;
      if (cmd_i.scan && iss_on_q) begin
        iss_idx_q <= iss_idx_q + 1'b1;
        if (iss_idx_q == LAST_IDX) iss_on_q <= 1'b0;
      end
      if (cmp_vld_q) begin
        if (cur_valid) begin
          count_q <= count_q + 1'b1;
          if (!found_q && key_rd_q == key_q) begin
            found_q   <= 1'b1;
            hit_idx_q <= cmp_idx_q;
            hit_age_q <= cur_age;
          end
          if (!have_old_q || cur_age > old_age_q) begin
            have_old_q <= 1'b1;
            old_idx_q  <= cmp_idx_q;
            old_age_q  <= cur_age;
          end
        end else if (!have_free_q) begin
          have_free_q <= 1'b1;
          free_idx_q  <= cmp_idx_q;
        end
      end
    end
  end

  // recency ranks, each entry updated in place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) age_q[i] <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (fill_en) begin
          if (IW'(i) == free_idx_q) begin
            valid_q[i] <= 1'b1;
            age_q[i]   <= '0;
          end else if (valid_q[i]) begin
            age_q[i] <= age_q[i] + 1'b1;
          end
        end else if (touch_en) begin
          if (IW'(i) == tgt_idx) begin
            age_q[i] <= '0;
          end else if (valid_q[i] && age_q[i] < tgt_age) begin
            age_q[i] <= age_q[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      read_value_q <= found_q ? data_rd_q : MISS_VALUE;
      hit_q        <= found_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign hit_o        = hit_q;

  assign sts_o.scan_done = cmp_vld_q && (cmp_idx_q == LAST_IDX);
  assign sts_o.is_set    = (func_q == FUNC_SET);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  `LKVC_ASSERT(a_fill_has_slot, clk_i, rst_ni, fill_en |-> have_free_q, "fill with no free slot")
  `LKVC_ASSERT(a_accept_clears, clk_i, rst_ni, cmd_i.accept |=> !found_q && !cmp_vld_q, "scan state not cleared")
  `LKVC_ASSERT_NEVER(a_respond_full, clk_i, rst_ni, cmd_i.respond && out_valid_q && out_stall_i, "result overwritten")

endmodule

FILE: rtl/lru_key_value_cache.sv
// a get result is loaded into the output register in the resp state, after the key scan
// one word at a time: a set ends at its commit, a get at its response, which waits
//   while the result register is full; the key scan reads one memory entry per cycle
// reset: all entries invalid, ranks zero, capacity 16; key/data memories not cleared
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value cache with least recently used replacement
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: capacity in use
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   lookup_key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  store_value_i,
  // result words, one per get
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lkvc_pkg::DATA_W-1:0]  read_value_o,
  output logic                                hit_o
);
  import lkvc_pkg::*;

  // flow of one word:
  //   idle   - word latched, scan accumulators cleared
  //   scan   - key memory read one entry per cycle, compared in the cycle after;
  //            the pass records the hit entry, the valid count, the oldest
  //            valid entry and the lowest free slot
  //   decide - a set updates in place, evicts the oldest or fills a free slot;
  //            a get reads the hit data
  //   resp   - a get loads the result register, a hit becomes most recent
  // the result register frees the controller while the word waits downstream

  lkvc_cmd_t cmd;
  lkvc_sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .lookup_key_i  (lookup_key_i),
    .store_value_i (store_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .hit_o         (hit_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

FILE: tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// feeds get and set words to the cache through a range of capacity settings
// and idle patterns, predicts every lookup with its own lru bookkeeping and
// compares each result word field by field
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int     ENTRIES     = 16;
  localparam int     PHASES      = 8;
  localparam int     PHASE_LEN   = 180;
  // a set gives no result word, so wait well past the end of its scan and commit
  localparam int     SETTLE      = 2 * ENTRIES + 8;
  localparam int     HOLD_LEN    = 400;
  localparam longint CYCLE_LIMIT = 600000;

  // one expected lookup result
  typedef struct {
    logic [DATA_W-1:0] value;
    logic              hit;
  } lookup_t;

  // lru bookkeeping: mirrors slot contents and recency ranks of the cache
  class lru_book;
    bit                valid[ENTRIES];
    logic [KEY_W-1:0]  key_mem[ENTRIES];
    logic [DATA_W-1:0] data_mem[ENTRIES];
    int unsigned       rank[ENTRIES];
    logic [CAP_W-1:0]  capacity;
    lookup_t           lookups[$];
    int                errors;

    function new();
      capacity = CAP_RESET;
      errors   = 0;
      foreach (valid[i]) begin
        valid[i]    = 1'b0;
        rank[i]     = 0;
        key_mem[i]  = '0;
        data_mem[i] = '0;
      end
    endfunction

    // make a slot the most recent, younger valid entries age by one
    function void promote(int idx);
      int unsigned own;
      own = rank[idx];
      foreach (valid[i])
        if (valid[i] && i != idx && rank[i] < own) rank[i]++;
      rank[idx] = 0;
    endfunction

    // accepted input word: update state, queue a lookup result for a get
    function void note_word(lkvc_func_e f, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
      int      found;
      int      free_slot;
      int      oldest;
      int      used;
      int      limit;
      lookup_t res;
      found     = -1;
      free_slot = -1;
      oldest    = -1;
      used      = 0;
      foreach (valid[i]) begin
        if (valid[i]) begin
          used++;
          if (found < 0 && key_mem[i] == k) found = i;
          if (oldest < 0 || rank[i] > rank[oldest]) oldest = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (f == FUNC_GET) begin
        if (found >= 0) begin
          res.hit   = 1'b1;
          res.value = data_mem[found];
          promote(found);
        end else begin
          res.hit   = 1'b0;
          res.value = MISS_VALUE;
        end
        lookups.push_back(res);
      end else if (found >= 0) begin
        data_mem[found] = v;
        promote(found);
      end else begin
        // zero acts as one, anything above the slot count as the slot count
        if (capacity == 0) limit = 1;
        else if (capacity > ENTRIES) limit = ENTRIES;
        else limit = capacity;
        if (used >= limit) begin
          key_mem[oldest]  = k;
          data_mem[oldest] = v;
          promote(oldest);
        end else begin
          foreach (valid[i])
            if (valid[i]) rank[i]++;
          valid[free_slot]    = 1'b1;
          key_mem[free_slot]  = k;
          data_mem[free_slot] = v;
          rank[free_slot]     = 0;
        end
      end
    endfunction

    // accepted result word against the oldest outstanding lookup
    function void check_result(logic [DATA_W-1:0] value, logic hit);
      lookup_t want;
      if (lookups.size() == 0) begin
        $display("%0t: unexpected result word, value %h hit %b", $time, value, hit);
        errors++;
        return;
      end
      want = lookups.pop_front();
      if (value !== want.value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.value, value);
        errors++;
      end
      if (hit !== want.hit) begin
        $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and block ports
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               func_i        = FUNC_GET;
  logic [KEY_W-1:0]   lookup_key_i  = '0;
  logic [DATA_W-1:0]  store_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [DATA_W-1:0]  read_value_o;
  logic               hit_o;

  lru_book book = new();

  // idle pattern knobs, percent of cycles
  int     snd_idle_pct  = 24;
  int     rcv_stall_pct = 63;
  // long receiver hold-off, requested by stimulus, counted down by the receiver
  bit     hold_req      = 1'b0;
  int     hold_left     = 0;
  longint cycles        = 0;

  logic [CAP_W-1:0] cap_plan[PHASES];
  logic [KEY_W-1:0] key_pool[32];

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .lookup_key_i (lookup_key_i),
    .store_value_i(store_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .hit_o        (hit_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // monitor: values sampled here are the ones present before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        book.note_word(lkvc_func_e'(func_i), lookup_key_i, store_value_i);
      if (out_valid_o && !out_stall_i)
        book.check_result(read_value_o, hit_o);
    end
  end

  // offer one word, with random idle cycles first, and wait for its acceptance
  // valid stays high on return so back-to-back words need no second assignment
  task automatic send_word(lkvc_func_e f, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    lookup_key_i  <= k;
    store_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering, wait for every outstanding lookup, then let a trailing set finish
  // it first waits for a clock edge so the monitor has noted the last accepted word
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // capacity write, only issued while the cache is idle
  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    book.capacity = v;
  endtask

  initial begin
    int               i;
    int               p;
    int               n;
    int               pool_n;
    lkvc_func_e       f;
    logic [KEY_W-1:0] k;
    logic [DATA_W-1:0] v;

    // extremes first, then mid values; zero and 31 cover every register bit
    cap_plan = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd16, 5'd9, 5'd17, 5'd2};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, default capacity
    send_word(FUNC_GET, 32'd0, 32'hFFFF_FFFF);          // get on an empty cache misses
    send_word(FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF);  // most negative key
    send_word(FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000);  // most positive key
    send_word(FUNC_SET, 32'd0, 32'd0);
    send_word(FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // stored value equals the miss code
    send_word(FUNC_GET, 32'h8000_0000, 32'h0);
    send_word(FUNC_GET, 32'hFFFF_FFFF, 32'h5555_5555);  // hit must still report hit
    send_word(FUNC_SET, 32'd0, 32'h1234_5678);          // overwrite a present key
    send_word(FUNC_GET, 32'd0, 32'h0);
    // fill the remaining slots, lowest free slot each time
    for (i = 1; i <= 12; i++)
      send_word(FUNC_SET, i, ~i);
    send_word(FUNC_SET, 32'd100, 32'hA5A5_A5A5);        // full, evicts the least recent
    send_word(FUNC_GET, 32'h7FFF_FFFF, 32'h0);          // the evicted key now misses
    drain();
    // capacity dropped below occupancy, nothing is dropped at the write
    write_capacity(5'd3);
    send_word(FUNC_SET, 32'd200, 32'h0BAD_F00D);        // replaces, occupancy stays
    send_word(FUNC_GET, 32'd1, 32'h0);
    send_word(FUNC_GET, 32'd100, 32'h0);
    drain();

    // random phases, one capacity setting each
    for (p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p]);
      case (p * 3 / PHASES)
        0: begin
          snd_idle_pct  = 24;
          rcv_stall_pct = 63;
        end
        1: begin
          snd_idle_pct  = 63;
          rcv_stall_pct = 24;
        end
        default: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
      endcase
      // small key pool so gets mostly hit; sizes below and above capacity
      pool_n = $urandom_range(24, 2);
      foreach (key_pool[j]) begin
        case ($urandom_range(9))
          0:       key_pool[j] = 32'h8000_0000;
          1:       key_pool[j] = 32'h7FFF_FFFF;
          2:       key_pool[j] = 32'h0;
          3:       key_pool[j] = 32'hFFFF_FFFF;
          default: key_pool[j] = $urandom;
        endcase
      end
      for (n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2) begin
          // receiver hold-off while words keep coming: the cache backs up
          if (p == 2 || p == 6) hold_req = 1'b1;
          // sender pause until nothing is outstanding
          if (p == 4) drain();
        end
        f = ($urandom_range(99) < 55) ? FUNC_GET : FUNC_SET;
        // mostly pool keys, the rest fully random and almost always absent
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(pool_n - 1)];
        else k = $urandom;
        case ($urandom_range(15))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h0;
          default: v = $urandom;
        endcase
        send_word(f, k, v);
      end
      drain();
    end

    if (book.errors == 0 && book.lookups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
